// File: rtl/median_filter_3x3_border_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the border-aware 3x3 median filter
// Clocked assertion helpers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_BORDER_DEFINES_SVH
`define MEDIAN_FILTER_3X3_BORDER_DEFINES_SVH

`ifndef SYNTH
// Checked property, switched off while reset is asserted.
`define MF3X3B_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mf3x3b assertion failed");
// Checked property, also checked while reset is asserted.
`define MF3X3B_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mf3x3b assertion failed");
`else
`define MF3X3B_ASSERT(lbl, clk, rst_n, prop)
`define MF3X3B_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/mf3x3b_pkg.sv
// ----------------------------------------------------------------------------
// mf3x3b_pkg
// Fixed constants of the border-aware 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3x3b_pkg;

  // Neighbors around the center; one mask bit each.
  localparam int unsigned NeighborCount = 8;
  // Center plus neighbors.
  localparam int unsigned WindowSize    = NeighborCount + 1;
  // Bits for a rank or a value count of 0 to WindowSize.
  localparam int unsigned CountBits     = $clog2(WindowSize + 1);

  typedef logic [CountBits-1:0] count_t;

endpackage

// File: rtl/mf3x3b_stream_if.sv
// ----------------------------------------------------------------------------
// mf3x3b stream interfaces
// Valid/ready channels for the window input and the median result.
// ----------------------------------------------------------------------------
interface mf3x3b_win_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                                     valid;
  logic                                     ready;
  logic [PIXEL_BITS-1:0]                    center_pixel;
  logic [PIXEL_BITS-1:0]                    left_pixel;
  logic [PIXEL_BITS-1:0]                    below_left_pixel;
  logic [PIXEL_BITS-1:0]                    below_pixel;
  logic [PIXEL_BITS-1:0]                    below_right_pixel;
  logic [PIXEL_BITS-1:0]                    right_pixel;
  logic [PIXEL_BITS-1:0]                    above_right_pixel;
  logic [PIXEL_BITS-1:0]                    above_pixel;
  logic [PIXEL_BITS-1:0]                    above_left_pixel;
  logic [mf3x3b_pkg::NeighborCount-1:0]     neighbor_valid;

  modport source (
    output valid, center_pixel, left_pixel, below_left_pixel, below_pixel,
           below_right_pixel, right_pixel, above_right_pixel, above_pixel,
           above_left_pixel, neighbor_valid,
    input  ready
  );

  modport sink (
    input  valid, center_pixel, left_pixel, below_left_pixel, below_pixel,
           below_right_pixel, right_pixel, above_right_pixel, above_pixel,
           above_left_pixel, neighbor_valid,
    output ready
  );
endinterface

interface mf3x3b_res_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] median_value;

  modport source (output valid, median_value, input ready);
  modport sink   (input valid, median_value, output ready);
endinterface

// File: rtl/median_filter_3x3_border.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_border
// Border-aware 3x3 median filter with registered input and output stages.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload
//   --------+-----------+-----------------------------------------------------
//   win_i   | in        | center pixel, eight neighbors, neighbor_valid mask
//   res_o   | out       | median_value
//
// One window transfer can be taken in every clock cycle unless both stages
// hold an item and res_o stalls. A window is held in the input register,
// ranked by the logic between the stages and held in the result register,
// from which its result is offered on res_o.
// Reset clears both stage valid flags; the data registers are not reset.
// When res_o stalls, the stages fill up and win_i.ready drops only once both
// stages hold an item; win_i.ready follows res_o.ready in the same cycle.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_border_defines.svh"

module median_filter_3x3_border #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mf3x3b_win_if.sink        win_i,
  mf3x3b_res_if.source      res_o
);

  localparam int unsigned WinSize = mf3x3b_pkg::WindowSize;

  // Input stage: window and mask of the item being ranked.
  logic                                   s1_valid_q, s1_valid_d;
  logic [WinSize-1:0][PIXEL_BITS-1:0]     s1_window_q;
  logic [WinSize-1:0]                     s1_used_q;
  // Result stage: finished median waiting for its transfer.
  logic                                   s2_valid_q, s2_valid_d;
  logic [PIXEL_BITS-1:0]                  s2_median_q;

  logic                                   s1_en;
  logic                                   s2_en;
  logic                                   in_xfer;
  logic [PIXEL_BITS-1:0]                  median_comb;

  // The result stage can take a new value when it is empty or is being
  // drained this cycle; the input stage can take one when it is empty or
  // passes its item forward.
  assign s2_en   = !s2_valid_q || res_o.ready;
  assign s1_en   = !s1_valid_q || s2_en;
  assign win_i.ready = s1_en;
  assign in_xfer = win_i.valid && s1_en;

  assign s1_valid_d = s1_en ? win_i.valid : s1_valid_q;
  assign s2_valid_d = s2_en ? s1_valid_q  : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // The center always takes part; neighbors only where the mask says so.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_window_q <= {win_i.above_left_pixel, win_i.above_pixel,
                      win_i.above_right_pixel, win_i.right_pixel,
                      win_i.below_right_pixel, win_i.below_pixel,
                      win_i.below_left_pixel, win_i.left_pixel,
                      win_i.center_pixel};
      s1_used_q   <= {win_i.neighbor_valid, 1'b1};
    end
  end

  mf3x3b_rank_select #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_rank_select (
    .window_i (s1_window_q),
    .used_i   (s1_used_q),
    .median_o (median_comb)
  );

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_median_q <= median_comb;
    end
  end

  assign res_o.valid        = s2_valid_q;
  assign res_o.median_value = s2_median_q;

  // A result only appears after an item sat in the input stage.
  `MF3X3B_ASSERT(a_res_from_s1, clk_i, rst_ni, $rose(s2_valid_q) |-> $past(s1_valid_q))
  // Input is refused only when both stages are occupied.
  `MF3X3B_ASSERT(a_ready_full, clk_i, rst_ni, !win_i.ready |-> (s1_valid_q && s2_valid_q))
  // With no neighbor inside the image, the median is the center itself.
  `MF3X3B_ASSERT(a_center_only, clk_i, rst_ni,
    (s2_en && s1_valid_q && (s1_used_q[WinSize-1:1] == '0)) |=>
      (s2_median_q == $past(s1_window_q[0])))
  // Reset leaves both stages empty on the next edge.
  `MF3X3B_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!s1_valid_q && !s2_valid_q))

endmodule

// File: rtl/mf3x3b_rank_select.sv
// ----------------------------------------------------------------------------
// mf3x3b_rank_select
// Median of the valid window entries by parallel ranking and selection.
// ----------------------------------------------------------------------------
module mf3x3b_rank_select #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic [mf3x3b_pkg::WindowSize-1:0][PIXEL_BITS-1:0] window_i,
  input  logic [mf3x3b_pkg::WindowSize-1:0]                 used_i,
  output logic [PIXEL_BITS-1:0]                             median_o
);

  localparam int unsigned WinSize = mf3x3b_pkg::WindowSize;

  mf3x3b_pkg::count_t                  rank   [WinSize];
  mf3x3b_pkg::count_t                  num_used;
  mf3x3b_pkg::count_t                  lo_rank;
  mf3x3b_pkg::count_t                  hi_rank;
  logic [WinSize-1:0]                  sel_lo;
  logic [WinSize-1:0]                  sel_hi;
  logic [PIXEL_BITS-1:0]               lo_val;
  logic [PIXEL_BITS-1:0]               hi_val;
  logic [PIXEL_BITS:0]                 pair_sum;

  // Each used entry gets a unique rank: entries that are smaller, or equal
  // and earlier in the window, sort before it.
  always_comb begin
    num_used = '0;
    for (int unsigned i = 0; i < WinSize; i++) begin
      num_used = num_used + mf3x3b_pkg::count_t'(used_i[i]);
      rank[i] = '0;
      for (int unsigned j = 0; j < WinSize; j++) begin
        if (j != i && used_i[j] &&
            ((window_i[j] < window_i[i]) ||
             ((window_i[j] == window_i[i]) && (j < i)))) begin
          rank[i] = rank[i] + mf3x3b_pkg::count_t'(1);
        end
      end
    end
  end

  // Odd count: both ranks name the middle entry. Even count: the two middle.
  assign lo_rank = (num_used - mf3x3b_pkg::count_t'(1)) >> 1;
  assign hi_rank = num_used >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int unsigned i = 0; i < WinSize; i++) begin
      sel_lo[i] = used_i[i] && (rank[i] == lo_rank);
      sel_hi[i] = used_i[i] && (rank[i] == hi_rank);
      lo_val    = lo_val | ({PIXEL_BITS{sel_lo[i]}} & window_i[i]);
      hi_val    = hi_val | ({PIXEL_BITS{sel_hi[i]}} & window_i[i]);
    end
  end

  assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign median_o = pair_sum[PIXEL_BITS:1];

endmodule

// File: verif/median_filter_3x3_border_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_border_tb
// Self-checking bench for the border-aware 3x3 median filter. Windows are sent
// through the valid/ready input channel with random gaps. The output channel
// stalls at random. Every accepted window is ranked by a behavioral model, and
// each median that leaves the block is checked in order against that model.
// ----------------------------------------------------------------------------
module median_filter_3x3_border_tb;

  localparam int unsigned PIXEL_BITS  = 8;
  localparam int          RandomItems = 1030;
  // The last stretch of random windows runs with no idling on either side.
  localparam int          CalmItems   = 150;

  // Window contents as the bench holds them. nbr[k] belongs to mask bit k.
  typedef struct packed {
    logic [mf3x3b_pkg::NeighborCount-1:0]                 valid_mask;
    logic [mf3x3b_pkg::NeighborCount-1:0][PIXEL_BITS-1:0] nbr;
    logic [PIXEL_BITS-1:0]                                center;
  } window_t;

  // Where a window sits along one image axis. OnlyLine is an image that is a
  // single row or column wide, so both neighbors on that axis are missing.
  typedef enum int {FirstLine, InnerLine, LastLine, OnlyLine} line_pos_e;

  // Keeps the medians that accepted windows must produce, oldest first, and
  // counts every disagreement with the block.
  class median_scoreboard;
    logic [PIXEL_BITS-1:0] median_queue[$];
    int                    faults;

    function new();
      faults = 0;
    endfunction

    // Rank the center together with the neighbors inside the image. An even
    // count yields the mean of the two middle values, rounded down; the sum
    // gets one extra bit so that it cannot wrap.
    function logic [PIXEL_BITS-1:0] median_of(window_t w);
      logic [PIXEL_BITS-1:0] vals [mf3x3b_pkg::WindowSize];
      logic [PIXEL_BITS-1:0] key;
      logic [PIXEL_BITS:0]   pair_sum;
      int                    cnt;
      int                    j;
      vals[0] = w.center;
      cnt     = 1;
      for (int k = 0; k < mf3x3b_pkg::NeighborCount; k++) begin
        if (w.valid_mask[k]) begin
          vals[cnt] = w.nbr[k];
          cnt++;
        end
      end
      for (int i = 1; i < cnt; i++) begin
        key = vals[i];
        j   = i;
        while (j > 0 && vals[j-1] > key) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = key;
      end
      if (cnt % 2 == 1) return vals[cnt/2];
      pair_sum = {1'b0, vals[cnt/2-1]} + {1'b0, vals[cnt/2]};
      return pair_sum[PIXEL_BITS:1];
    endfunction

    function void note_window(window_t w);
      median_queue.push_back(median_of(w));
    endfunction

    function void check_median(logic [PIXEL_BITS-1:0] got);
      logic [PIXEL_BITS-1:0] want;
      if (median_queue.size() == 0) begin
        $display("%0t: median %0d arrived with no window outstanding", $time, got);
        faults++;
      end else begin
        want = median_queue.pop_front();
        if (got !== want) begin
          $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, got);
          faults++;
        end
      end
    endfunction

    function int pending();
      return median_queue.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm_phase;

  median_scoreboard sb;

  mf3x3b_win_if #(.PIXEL_BITS(PIXEL_BITS)) win ();
  mf3x3b_res_if #(.PIXEL_BITS(PIXEL_BITS)) res ();

  median_filter_3x3_border #(
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .win_i (win),
    .res_o (res)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Neighbor mask that the frame walk would produce for a window at the given
  // row and column position. Mask bits follow the neighbor order of the ports.
  function automatic logic [mf3x3b_pkg::NeighborCount-1:0] border_mask(
      line_pos_e row, line_pos_e col);
    logic above_ok;
    logic below_ok;
    logic left_ok;
    logic right_ok;
    logic [mf3x3b_pkg::NeighborCount-1:0] m;
    above_ok = (row == InnerLine) || (row == LastLine);
    below_ok = (row == FirstLine) || (row == InnerLine);
    left_ok  = (col == InnerLine) || (col == LastLine);
    right_ok = (col == FirstLine) || (col == InnerLine);
    m[0] = left_ok;
    m[1] = below_ok && left_ok;
    m[2] = below_ok;
    m[3] = below_ok && right_ok;
    m[4] = right_ok;
    m[5] = above_ok && right_ok;
    m[6] = above_ok;
    m[7] = above_ok && left_ok;
    return m;
  endfunction

  // One pixel in the given flavor: anything, an extreme value, or a value
  // close to base so that windows are full of ties.
  function automatic logic [PIXEL_BITS-1:0] pick_pixel(int flavor, int base);
    case (flavor)
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      2: return 8'(base + $urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly windows at plausible image positions; the rest carry arbitrary
  // masks, which the block must handle just the same.
  function automatic window_t random_window();
    window_t w;
    int      flavor;
    int      base;
    flavor = $urandom_range(0, 3);
    base   = $urandom_range(0, 252);
    w.center = pick_pixel(flavor, base);
    for (int k = 0; k < mf3x3b_pkg::NeighborCount; k++) w.nbr[k] = pick_pixel(flavor, base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        w.valid_mask = border_mask(line_pos_e'($urandom_range(0, 3)),
                                   line_pos_e'($urandom_range(0, 3)));
      6, 7: w.valid_mask = '1;
      default: w.valid_mask = 8'($urandom);
    endcase
    return w;
  endfunction

  // Present one window and hold it until the block takes it. Valid is raised
  // here and lowered only by idle_source or after the last window, so
  // back-to-back transfers keep valid high without a glitch.
  task automatic send_window(window_t w);
    win.valid             <= 1'b1;
    win.center_pixel      <= w.center;
    win.left_pixel        <= w.nbr[0];
    win.below_left_pixel  <= w.nbr[1];
    win.below_pixel       <= w.nbr[2];
    win.below_right_pixel <= w.nbr[3];
    win.right_pixel       <= w.nbr[4];
    win.above_right_pixel <= w.nbr[5];
    win.above_pixel       <= w.nbr[6];
    win.above_left_pixel  <= w.nbr[7];
    win.neighbor_valid    <= w.valid_mask;
    do @(posedge clk_i); while (win.ready !== 1'b1);
    sb.note_window(w);
  endtask

  task automatic idle_source(int cycles);
    win.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle(int gap_odds);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      idle_source($urandom_range(1, 13));
    end
  endtask

  // Result side: every transfer on res_o is checked against the oldest
  // expected median. Values are taken at the edge, before any update.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      sb.check_median(res.median_value);
    end
  end

  // Downstream backpressure. Stalls come in bursts, and their frequency
  // changes from time to time, including stretches with none.
  // Once the calm phase starts, ready stays high.
  initial begin
    int stall_left;
    int stall_odds;
    int cycle_cnt;
    stall_left = 0;
    stall_odds = 4;
    cycle_cnt  = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt % 200 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 4;
          default: stall_odds = 12;
        endcase
      end
      if (calm_phase) begin
        stall_left = 0;
      end else if (stall_left == 0 && stall_odds != 0 &&
                   $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Main stimulus: reset, a directed set of windows, then random windows.
  initial begin
    window_t w;
    int      gap_odds;
    sb         = new();
    calm_phase = 1'b0;
    rst_ni                <= 1'b0;
    win.valid             <= 1'b0;
    win.center_pixel      <= '0;
    win.left_pixel        <= '0;
    win.below_left_pixel  <= '0;
    win.below_pixel       <= '0;
    win.below_right_pixel <= '0;
    win.right_pixel       <= '0;
    win.above_right_pixel <= '0;
    win.above_pixel       <= '0;
    win.above_left_pixel  <= '0;
    win.neighbor_valid    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_odds = 4;

    // A lone pixel: only the center counts, whatever the neighbors hold.
    w.valid_mask = '0;
    w.center     = '0;
    w.nbr        = '1;
    send_window(w);
    maybe_idle(gap_odds);
    w.center = '1;
    w.nbr    = '0;
    send_window(w);
    maybe_idle(gap_odds);

    // Each neighbor alone with the center: a count of two, averaged down.
    // The masked-off neighbors hold zero, which would pull the result down
    // if they were counted.
    for (int k = 0; k < mf3x3b_pkg::NeighborCount; k++) begin
      w.center     = '0;
      w.nbr        = '0;
      w.nbr[k]     = '1;
      w.valid_mask = '0;
      w.valid_mask[k] = 1'b1;
      send_window(w);
      maybe_idle(gap_odds);
    end

    // Full interior windows at the value extremes and with distinct values.
    w.valid_mask = '1;
    w.center     = '1;
    w.nbr        = '1;
    send_window(w);
    maybe_idle(gap_odds);
    w.center = '0;
    w.nbr    = '0;
    send_window(w);
    maybe_idle(gap_odds);
    w.center = '1;
    send_window(w);
    maybe_idle(gap_odds);
    w.center = 8'd200;
    w.nbr    = {8'd3, 8'd250, 8'd17, 8'd96, 8'd128, 8'd5, 8'd77, 8'd199};
    send_window(w);
    maybe_idle(gap_odds);

    // Eight values: the two middle values are both at full scale, so their
    // sum needs the extra bit.
    w.valid_mask = 8'h7F;
    w.center     = '1;
    w.nbr        = '1;
    send_window(w);
    maybe_idle(gap_odds);

    // Eight values split evenly between zero and full scale.
    w.valid_mask = 8'hFE;
    w.center     = '0;
    w.nbr        = {4{8'hFF, 8'h00}};
    send_window(w);
    maybe_idle(gap_odds);

    // Every edge and corner position of an image, random contents.
    for (int r = FirstLine; r <= LastLine; r++) begin
      for (int c = FirstLine; c <= LastLine; c++) begin
        if (r != InnerLine || c != InnerLine) begin
          w            = random_window();
          w.valid_mask = border_mask(line_pos_e'(r), line_pos_e'(c));
          send_window(w);
          maybe_idle(gap_odds);
        end
      end
    end

    // Random windows. The gap rate on the input side changes every 64 windows.
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 10;
        endcase
      end
      if (i >= RandomItems - CalmItems) begin
        calm_phase = 1'b1;
        gap_odds   = 0;
      end
      send_window(random_window());
      maybe_idle(gap_odds);
    end
    win.valid <= 1'b0;

    // Drain: wait for every expected median, then a few more cycles so that a
    // stray extra result would still be seen.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: median_filter_3x3_border.f
+incdir+rtl
rtl/mf3x3b_pkg.sv
rtl/mf3x3b_stream_if.sv
rtl/mf3x3b_rank_select.sv
rtl/median_filter_3x3_border.sv
verif/median_filter_3x3_border_tb.sv
